// ===== rtl/chmap_pkg.sv =====
// ----------------------------------------------------------------------------
// chmap_pkg
// Shared widths, coefficients and register codes for the cubehelix colormap.
// ----------------------------------------------------------------------------
package chmap_pkg;

  localparam int SAMPLE_BITS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = SAMPLE_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START = 4'd0,
    REG_SPAN  = 4'd1,
    REG_LOW   = 4'd2,
    REG_HIGH  = 4'd3
  } cfg_reg_t;

  // datapath widths
  localparam int VDW = SAMPLE_BITS + 1;   // bound difference, sample minus low
  localparam int MW  = SAMPLE_BITS + 10;  // scaled products
  localparam int NW  = SAMPLE_BITS + 11;  // numerator
  localparam int AW  = SAMPLE_BITS + 9;   // numerator magnitude
  localparam int DW  = SAMPLE_BITS + 8;   // denominator, 255 * |high - low|
  localparam int CW  = DW + 4;            // overflow compare width

  localparam int DIV_STEPS   = 20;        // quotient bits, covers +-8.0 in Q16
  localparam int FW          = DIV_STEPS + 1;
  localparam int Q_ONE       = 65536;
  localparam int FRACT_LIMIT = 8 * Q_ONE;

  localparam int PRW       = 2 * FW;      // fract * (1 - fract)
  localparam int LOW_SPLIT = FW;          // split point of the coefficient product
  localparam int KW        = 18;
  localparam int PPW       = 40;          // partial product width
  localparam int SW        = 60;          // full coefficient product width
  localparam int AMP_SHIFT = 33;
  localparam int AMPW      = SW - AMP_SHIFT;
  localparam int CLW       = AMPW + 1;
  localparam int CHW       = 17;          // clamped channel, 0 to 1.0 in Q16

  localparam int NCH = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam logic signed [KW-1:0] K_COEF [NCH] = '{
    18'sd96313, -18'sd61026, 18'sd64649
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       err;
  } pix_t;

endpackage

// ===== rtl/cubehelix_range_colormap_top.sv =====
// ----------------------------------------------------------------------------
// cubehelix_range_colormap_top
// Pipelined cubehelix pseudocolor of one signed sample over a bounded range.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  input    in         in_valid / in_stall   sample
//  output   out        out_valid / out_stall red, green, blue, bound_error
//  config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One sample per clock while in_stall is low.
//  The fraction comes from a 20 stage restoring divider, one quotient bit per
//  stage; the rest is multiply, scale and clamp stages.
//  A two entry output buffer keeps the pipe moving while a result waits;
//  in_stall rises only once both entries are full.
//  Synchronous reset clears valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module cubehelix_range_colormap_top
  import chmap_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic                          bound_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int S_MUL     = 1;
  localparam int S_NUM     = 2;
  localparam int S_ABS     = 3;
  localparam int DIV_FIRST = 4;
  localparam int DIV_LAST  = DIV_FIRST + DIV_STEPS;
  localparam int NS        = DIV_LAST + 8;

  // configuration registers
  logic [7:0]                    start_level;
  logic [7:0]                    span_level;
  logic signed [SAMPLE_BITS-1:0] low_bound;
  logic signed [SAMPLE_BITS-1:0] high_bound;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level <= 8'd0;
      span_level  <= 8'd255;
      low_bound   <= '0;
      high_bound  <= SAMPLE_BITS'(32767);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START: start_level <= cfg_data[7:0];
        REG_SPAN:  span_level  <= cfg_data[7:0];
        REG_LOW:   low_bound   <= cfg_data[SAMPLE_BITS-1:0];
        REG_HIGH:  high_bound  <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // values derived from the registers, registered in the cycle after them
  logic signed [VDW-1:0]         d_c;
  logic signed [VDW-1:0]         dabs_c;
  logic [8:0]                    top_sum;
  logic signed [VDW-1:0]         d_q;
  logic                          dneg_q;
  logic                          zero_q;
  logic [DW-1:0]                 den_q;
  logic [7:0]                    sp_q;
  logic [7:0]                    top_q;

  always_comb begin
    d_c     = VDW'(high_bound) - VDW'(low_bound);
    dabs_c  = d_c[VDW-1] ? -d_c : d_c;
    top_sum = {1'b0, start_level} + {1'b0, span_level};
  end

  always_ff @(posedge clk) begin
    d_q    <= d_c;
    dneg_q <= d_c[VDW-1];
    zero_q <= (d_c == '0);
    den_q  <= {dabs_c[SAMPLE_BITS-1:0], 8'd0} - DW'(dabs_c[SAMPLE_BITS-1:0]);
    // span limited to 255 - start
    sp_q   <= top_sum[8] ? ~start_level : span_level;
    top_q  <= top_sum[8] ? 8'hFF : top_sum[7:0];
  end

  // pipeline control
  logic [NS-1:0]   vld;
  logic [NS-2:1]   err_s;
  logic            pipe_en;
  logic            push;
  logic            take;
  logic            spare_valid;
  pix_t            spare_pix;
  pix_t            out_pix;
  pix_t            last_pix;

  assign pipe_en  = !spare_valid;
  assign in_stall = spare_valid;
  assign push     = pipe_en && vld[NS-1];
  assign take     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (pipe_en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // stage payloads
  logic signed [VDW-1:0] vd0;
  logic signed [MW-1:0]  m1_1;
  logic signed [MW-1:0]  m2_1;
  logic signed [NW-1:0]  num2;
  logic [AW-1:0]         a3;
  logic                  neg_s [S_ABS:DIV_LAST];
  logic                  ovf_s [DIV_FIRST:DIV_LAST];
  logic [DW-1:0]         dr    [DIV_FIRST:DIV_LAST];
  logic [3:0]            nib   [DIV_FIRST:DIV_LAST];
  logic [DIV_STEPS-1:0]  quo   [DIV_FIRST:DIV_LAST];
  logic signed [FW-1:0]  f25;
  logic signed [FW-1:0]  f26;
  logic signed [FW-1:0]  om26;
  logic signed [FW-1:0]  f27;
  logic signed [PRW-1:0] p27;
  logic signed [FW-1:0]  f28;
  logic signed [PPW-1:0] pp_hi [NCH];
  logic signed [PPW-1:0] pp_lo [NCH];
  logic signed [FW-1:0]  f29;
  logic signed [AMPW-1:0] amp29 [NCH];
  logic [CHW-1:0]        cl30  [NCH];

  // combinational helpers
  logic signed [MW-1:0]  top_ext;
  logic signed [NW-1:0]  num_abs;
  logic [DW:0]           div_trial [DIV_STEPS];
  logic [DW+1:0]         div_sub   [DIV_STEPS];
  logic                  div_ge    [DIV_STEPS];
  logic [DW-1:0]         dr_next   [DIV_STEPS];
  logic                  rnz;
  logic [FW-1:0]         mag_up;
  logic signed [FW-1:0]  f_c;
  logic signed [FW-1:0]  p_hi;
  logic signed [FW:0]    p_lo;
  logic signed [SW-1:0]  prod_c [NCH];
  logic signed [CLW-1:0] ch_c   [NCH];
  logic [CHW+7:0]        scl_c  [NCH];

  always_comb begin
    top_ext = MW'($signed({1'b0, top_q}));
    num_abs = num2[NW-1] ? -num2 : num2;

    for (int j = 0; j < DIV_STEPS; j++) begin
      div_trial[j] = {dr[DIV_FIRST+j], nib[DIV_FIRST+j][3]};
      div_ge[j]    = div_trial[j] >= {1'b0, den_q};
      div_sub[j]   = {1'b0, div_trial[j]} - {2'b00, den_q};
      dr_next[j]   = div_ge[j] ? div_sub[j][DW-1:0] : div_trial[j][DW-1:0];
    end

    // floor of the signed quotient, saturated to +-8.0
    rnz    = (dr[DIV_LAST] != '0);
    mag_up = {1'b0, quo[DIV_LAST]} + FW'(rnz);
    if (!neg_s[DIV_LAST]) begin
      if (ovf_s[DIV_LAST] || ({1'b0, quo[DIV_LAST]} > FW'(FRACT_LIMIT))) begin
        f_c = FW'(FRACT_LIMIT);
      end else begin
        f_c = FW'({1'b0, quo[DIV_LAST]});
      end
    end else begin
      if (ovf_s[DIV_LAST] || (mag_up > FW'(FRACT_LIMIT))) begin
        f_c = FW'(-FRACT_LIMIT);
      end else begin
        f_c = -$signed(mag_up);
      end
    end

    p_hi = p27[PRW-1:LOW_SPLIT];
    p_lo = {1'b0, p27[LOW_SPLIT-1:0]};

    for (int c = 0; c < NCH; c++) begin
      prod_c[c] = (SW'(pp_hi[c]) <<< LOW_SPLIT) + SW'(pp_lo[c]);
      ch_c[c]   = CLW'(f29) + CLW'(amp29[c]);
      scl_c[c]  = {cl30[c], 8'd0} - (CHW+8)'(cl30[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      err_s <= {err_s[NS-3:1], zero_q};

      vd0  <= VDW'(sample) - VDW'(low_bound);

      m1_1 <= top_ext * MW'(d_q);
      m2_1 <= MW'(vd0) * MW'($signed({1'b0, sp_q}));

      num2 <= NW'(m1_1) - NW'(m2_1);

      a3           <= num_abs[AW-1:0];
      neg_s[S_ABS] <= num2[NW-1] ^ dneg_q;

      // divider setup: quotient must stay below 2^20
      ovf_s[DIV_FIRST] <= CW'(a3) >= {den_q, 4'd0};
      dr[DIV_FIRST]    <= DW'(a3 >> 4);
      nib[DIV_FIRST]   <= a3[3:0];
      quo[DIV_FIRST]   <= '0;
      neg_s[DIV_FIRST] <= neg_s[S_ABS];

      for (int j = 0; j < DIV_STEPS; j++) begin
        dr[DIV_FIRST+j+1]    <= dr_next[j];
        nib[DIV_FIRST+j+1]   <= {nib[DIV_FIRST+j][2:0], 1'b0};
        quo[DIV_FIRST+j+1]   <= {quo[DIV_FIRST+j][DIV_STEPS-2:0], div_ge[j]};
        ovf_s[DIV_FIRST+j+1] <= ovf_s[DIV_FIRST+j];
        neg_s[DIV_FIRST+j+1] <= neg_s[DIV_FIRST+j];
      end

      f25  <= f_c;

      f26  <= f25;
      om26 <= FW'(Q_ONE) - f25;

      f27  <= f26;
      p27  <= f26 * om26;

      f28  <= f27;
      f29  <= f28;
      for (int c = 0; c < NCH; c++) begin
        pp_hi[c] <= PPW'(p_hi) * PPW'(K_COEF[c]);
        pp_lo[c] <= PPW'(p_lo) * PPW'(K_COEF[c]);
        amp29[c] <= prod_c[c][SW-1:AMP_SHIFT];
        if (ch_c[c][CLW-1]) begin
          cl30[c] <= '0;
        end else if (ch_c[c][CLW-2:0] > (CLW-1)'(Q_ONE)) begin
          cl30[c] <= CHW'(Q_ONE);
        end else begin
          cl30[c] <= ch_c[c][CHW-1:0];
        end
      end

      last_pix.err   <= err_s[NS-2];
      last_pix.red   <= err_s[NS-2] ? 8'd0 : scl_c[CH_RED][CHW+6:CHW-1];
      last_pix.green <= err_s[NS-2] ? 8'd0 : scl_c[CH_GREEN][CHW+6:CHW-1];
      last_pix.blue  <= err_s[NS-2] ? 8'd0 : scl_c[CH_BLUE][CHW+6:CHW-1];
    end
  end

  // output register with one spare entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (take) begin
        spare_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (take) begin
        out_pix <= spare_pix;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_pix <= last_pix;
      end else begin
        spare_pix <= last_pix;
      end
    end
  end

  assign red         = out_pix.red;
  assign green       = out_pix.green;
  assign blue        = out_pix.blue;
  assign bound_error = out_pix.err;

endmodule

// ===== rtl/chmap_checker.sv =====
// ----------------------------------------------------------------------------
// chmap_checker
// Port level checks for the cubehelix colormap, bound to the top level.
// ----------------------------------------------------------------------------
module chmap_checker
  import chmap_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       bound_error,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) &&
      $stable(blue) && $stable(bound_error))
    else $error("result changed while stalled");

  // equal bounds always give black
  a_err_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && bound_error |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("bound error without black output");

  // input backs up only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // reset empties the output side and frees the input
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("output not cleared by reset");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration transaction refused");

endmodule

bind cubehelix_range_colormap_top chmap_checker u_chmap_checker (.*);
